>>> rtl/core/table_driven_dfa_runner_unit_macros.svh
`ifndef TABLE_DRIVEN_DFA_RUNNER_UNIT_MACROS_SVH
`define TABLE_DRIVEN_DFA_RUNNER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define TDDFA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define TDDFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tddfa_pkg.sv
package tddfa_pkg;

	localparam int STATE_W = 4;
	localparam int SYM_W = 4;
	localparam int NSTATES_W = 5;
	localparam int PROD_W = SYM_W + NSTATES_W;

	localparam int DEF_MAX_STATES = 16;
	localparam int DEF_MAX_SYMBOLS = 16;

	localparam int OUT_FIFO_DEPTH = 8;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	localparam logic [STATE_W-1:0] START_STATE = '0;

	typedef struct packed {
		logic               req_type;
		logic               last;
		logic [STATE_W-1:0] from_state;
		logic [STATE_W-1:0] to_state;
	} op_t;

	typedef struct packed {
		logic [STATE_W-1:0] final_state;
		logic               accepted;
	} res_t;

endpackage

>>> rtl/core/tddfa_if.sv
interface tddfa_req_if import tddfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [STATE_W-1:0] from_state;
	logic [SYM_W-1:0]   symbol;
	logic [STATE_W-1:0] to_state;
	logic               last;

	modport source (output valid, req_type, from_state, symbol, to_state, last, input ready);
	modport sink (input valid, req_type, from_state, symbol, to_state, last, output ready);
endinterface

interface tddfa_res_if import tddfa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STATE_W-1:0] final_state;
	logic               accepted;

	modport source (output valid, final_state, accepted, input ready);
	modport sink (input valid, final_state, accepted, output ready);
endinterface

interface tddfa_cfg_if import tddfa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [NSTATES_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/table_driven_dfa_runner_unit.sv
// Datapath: an input transfer passes 3 address stages (product, quotient, remainder),
// then the table read and the result queue, where its result may wait behind earlier results.
// Throughput: one item per cycle while the queue has credit; the bound is the loop from
// the table read data to the next read address via one add and one compare-subtract.
// Reset: stride 1, current state 0, pipeline and result queue empty; the transition
// table is not cleared and holds undefined data until loaded.
`include "table_driven_dfa_runner_unit_macros.svh"

module table_driven_dfa_runner_unit import tddfa_pkg::*; #(
	parameter int MAX_STATES = DEF_MAX_STATES,
	parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS
) (
	input  logic        clk,
	input  logic        arst_n,
	tddfa_cfg_if.sink   cfg,
	tddfa_req_if.sink   req,
	tddfa_res_if.source res
);

	localparam int TableDepth = MAX_STATES * MAX_SYMBOLS;
	localparam int AW = $clog2(TableDepth);
	localparam int StateVals = 2 ** STATE_W;
	localparam int RecipK = PROD_W + AW;
	localparam logic [PROD_W:0] Recip = (PROD_W + 1)'((2 ** RecipK) / TableDepth);
	localparam int RW = PROD_W + AW + 1;
	localparam int PtrW = $clog2(OUT_FIFO_DEPTH);
	localparam int CntW = PtrW + 1;
	localparam int OccW = CntW + 1;

	function automatic logic [StateVals*AW-1:0] mod_table();
		logic [StateVals*AW-1:0] tab;
		tab = '0;
		for (int i = 0; i < StateVals; i++) begin
			tab[i*AW +: AW] = AW'(i % TableDepth);
		end
		return tab;
	endfunction

	localparam logic [StateVals*AW-1:0] ModTab = mod_table();

	logic [NSTATES_W-1:0] stride_q;
	logic [STATE_W-1:0]   cur_q;

	logic                 v_s1, v_s2, v_s3, v_s4;
	op_t                  op_s1, op_s2, op_s3;
	logic [PROD_W-1:0]    p_s1, p_s2;
	logic [PROD_W-1:0]    q_s2;
	logic [AW-1:0]        base_s3;
	logic                 step_s4, last_s4;
	logic [STATE_W-1:0]   rd_data_s4;

	logic [STATE_W-1:0]   table_mem [TableDepth];

	res_t                 fifo_mem [OUT_FIFO_DEPTH];
	logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]      fifo_cnt_q;

	logic                 req_xfer, push_c, pop_c;
	logic [OccW-1:0]      occ_c;
	logic [2*PROD_W:0]    recip_prod;
	logic [RW-1:0]        qd, rem_raw, rem;
	logic [STATE_W-1:0]   cur_eff, sel_state;
	logic [AW-1:0]        sel_red;
	logic [AW:0]          addr_sum;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we, mem_re;

	// configuration: clamp the stride once at write time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= NSTATES_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.data == '0) begin
				stride_q <= NSTATES_W'(1);
			end else if (int'(cfg.data) > MAX_STATES) begin
				stride_q <= NSTATES_W'(MAX_STATES);
			end else begin
				stride_q <= cfg.data;
			end
		end
	end

	// credit check against the result queue
	assign occ_c = OccW'(fifo_cnt_q) + OccW'(v_s1) + OccW'(v_s2) + OccW'(v_s3) + OccW'(v_s4);
	assign req.ready = occ_c < OccW'(OUT_FIFO_DEPTH);
	assign req_xfer = req.valid && req.ready;

	// address pipeline: product, reciprocal quotient, remainder
	assign recip_prod = (2*PROD_W + 1)'(p_s1) * (2*PROD_W + 1)'(Recip);
	assign qd = RW'(q_s2) * RW'(TableDepth);
	assign rem_raw = RW'(p_s2) - qd;
	assign rem = (rem_raw >= RW'(TableDepth)) ? rem_raw - RW'(TableDepth) : rem_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= req_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1.req_type   <= req.req_type;
		op_s1.last       <= req.last;
		op_s1.from_state <= req.from_state;
		op_s1.to_state   <= req.to_state;
		p_s1             <= PROD_W'(req.symbol) * PROD_W'(stride_q);
		op_s2            <= op_s1;
		p_s2             <= p_s1;
		q_s2             <= PROD_W'(recip_prod >> RecipK);
		op_s3            <= op_s2;
		base_s3          <= AW'(rem);
		step_s4          <= op_s3.req_type == REQ_STEP;
		last_s4          <= op_s3.last;
	end

	// on a returning step take the state from the read data, or the start state if last
	always_comb begin
		if (v_s4 && step_s4) begin
			cur_eff = last_s4 ? START_STATE : rd_data_s4;
		end else begin
			cur_eff = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= START_STATE;
		end else begin
			cur_q <= cur_eff;
		end
	end

	assign sel_state = (op_s3.req_type == REQ_STEP) ? cur_eff : op_s3.from_state;
	assign sel_red = ModTab[sel_state*AW +: AW];
	assign addr_sum = (AW + 1)'(base_s3) + (AW + 1)'(sel_red);
	assign mem_addr = (addr_sum >= (AW + 1)'(TableDepth)) ?
		AW'(addr_sum - (AW + 1)'(TableDepth)) : AW'(addr_sum);
	assign mem_we = v_s3 && (op_s3.req_type == REQ_LOAD);
	assign mem_re = v_s3 && (op_s3.req_type == REQ_STEP);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_addr] <= op_s3.to_state;
		end
		if (mem_re) begin
			rd_data_s4 <= table_mem[mem_addr];
		end
	end

	// result queue
	assign push_c = v_s4 && step_s4 && last_s4;
	assign pop_c = res.valid && res.ready;
	assign res.valid = fifo_cnt_q != '0;
	assign res.final_state = fifo_mem[rd_ptr_q].final_state;
	assign res.accepted = fifo_mem[rd_ptr_q].accepted;

	always_ff @(posedge clk) begin
		if (push_c) begin
			fifo_mem[wr_ptr_q].final_state <= rd_data_s4;
			fifo_mem[wr_ptr_q].accepted    <= rd_data_s4 == START_STATE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push_c) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop_c) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push_c && !pop_c) begin
				fifo_cnt_q <= fifo_cnt_q + CntW'(1);
			end else if (pop_c && !push_c) begin
				fifo_cnt_q <= fifo_cnt_q - CntW'(1);
			end
		end
	end

	`TDDFA_ASSERT_SAME(a_fifo_room, push_c, (fifo_cnt_q < CntW'(OUT_FIFO_DEPTH)) || pop_c, "result queue overflow")
	`TDDFA_ASSERT_SAME(a_occ_bound, 1'b1, occ_c <= OccW'(OUT_FIFO_DEPTH), "in-flight items exceed queue credit")
	`TDDFA_ASSERT_NEXT(a_state_rewind, push_c, cur_q == START_STATE, "state not rewound after last symbol")
	`TDDFA_ASSERT_SAME(a_accept_flag, res.valid, res.accepted == (res.final_state == START_STATE), "accept flag mismatch")
	`TDDFA_ASSERT_NEXT(a_pipe_fill, req_xfer, v_s1, "transfer lost at pipeline entry")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top import tddfa_pkg::*; ();

	typedef struct packed {
		logic               kind;
		logic [STATE_W-1:0] src;
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] dst;
		logic               last;
	} dfa_req_t;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic               acc;
	} verdict_t;

	typedef struct {
		logic               kind;
		logic [STATE_W-1:0] src;
		logic [SYM_W-1:0]   sym;
		logic [STATE_W-1:0] dst;
		logic               last;
		bit                 typed;
		logic [STATE_W-1:0] want_state;
		logic               want_acc;
	} script_row_t;

	localparam int TABLE_DEPTH = DEF_MAX_STATES * DEF_MAX_SYMBOLS;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int ITEM_TARGET = 1200;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_ITEMS = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tddfa_cfg_if cfg_bus();
	tddfa_req_if req_bus();
	tddfa_res_if res_bus();

	table_driven_dfa_runner_unit u_dut (
		.clk,
		.arst_n,
		.cfg(cfg_bus),
		.req(req_bus),
		.res(res_bus)
	);

	logic [STATE_W-1:0]   next_state_mem [TABLE_DEPTH];
	bit                   loaded [TABLE_DEPTH];
	logic [STATE_W-1:0]   dfa_state = START_STATE;
	logic [NSTATES_W-1:0] num_states_reg = 5'd1;
	verdict_t             verdicts_due [$];
	script_row_t          script [12];

	int  err_cnt = 0;
	int  load_cnt = 0;
	int  step_cnt = 0;
	int  verdict_cnt = 0;
	int  accept_cnt = 0;
	int  cfg_cnt = 0;
	int  stall_left = 0;
	bit  quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int stride_of(input logic [NSTATES_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > DEF_MAX_STATES)
			return DEF_MAX_STATES;
		return int'(n);
	endfunction

	function automatic logic [ADDR_W-1:0] entry_addr(input logic [SYM_W-1:0] sym,
		input logic [STATE_W-1:0] st);
		return ADDR_W'((int'(sym) * stride_of(num_states_reg) + int'(st)) % TABLE_DEPTH);
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void dfa_apply(input dfa_req_t rq, output bit emits, output verdict_t v);
		logic [ADDR_W-1:0] a;
		emits = 1'b0;
		v = '0;
		if (rq.kind == REQ_LOAD) begin
			a = entry_addr(rq.sym, rq.src);
			next_state_mem[a] = rq.dst;
			loaded[a] = 1'b1;
			load_cnt++;
		end else begin
			a = entry_addr(rq.sym, dfa_state);
			dfa_state = next_state_mem[a];
			step_cnt++;
			if (rq.last) begin
				emits = 1'b1;
				v.state = dfa_state;
				v.acc = (dfa_state == START_STATE);
				dfa_state = START_STATE;
			end
		end
	endfunction

	task automatic send_item(input dfa_req_t rq, input bit typed, input verdict_t want);
		bit emits;
		verdict_t v;
		req_bus.valid <= 1'b1;
		req_bus.req_type <= rq.kind;
		req_bus.from_state <= rq.src;
		req_bus.symbol <= rq.sym;
		req_bus.to_state <= rq.dst;
		req_bus.last <= rq.last;
		do @(posedge clk); while (!req_bus.ready);
		dfa_apply(rq, emits, v);
		if (emits)
			verdicts_due.push_back(typed ? want : v);
		accept_cnt++;
	endtask

	task automatic req_pause();
		int n;
		n = gap_len();
		if (n > 0) begin
			req_bus.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [NSTATES_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		num_states_reg = value;
		cfg_cnt++;
	endtask

	task automatic send_random_load();
		dfa_req_t rq;
		rq.kind = REQ_LOAD;
		rq.src = STATE_W'($urandom_range(0, 15));
		rq.sym = SYM_W'($urandom_range(0, 15));
		rq.dst = STATE_W'($urandom_range(0, 15));
		rq.last = 1'($urandom_range(0, 1));
		send_item(rq, 1'b0, '0);
		req_pause();
	endtask

	// Never read an entry that was not loaded: pick a loaded symbol, or load one first.
	task automatic step_on(input logic [SYM_W-1:0] pref, input logic last);
		logic [SYM_W-1:0] s;
		int tries;
		dfa_req_t rq;
		s = pref;
		tries = 0;
		while (!loaded[entry_addr(s, dfa_state)] && tries < 16) begin
			s = s + SYM_W'(1);
			tries++;
		end
		if (!loaded[entry_addr(s, dfa_state)]) begin
			rq.kind = REQ_LOAD;
			rq.src = dfa_state;
			rq.sym = s;
			rq.dst = STATE_W'($urandom_range(0, 15));
			rq.last = 1'($urandom_range(0, 1));
			send_item(rq, 1'b0, '0);
			req_pause();
		end
		rq.kind = REQ_STEP;
		rq.src = STATE_W'($urandom_range(0, 15));
		rq.sym = s;
		rq.dst = STATE_W'($urandom_range(0, 15));
		rq.last = last;
		send_item(rq, 1'b0, '0);
		req_pause();
	endtask

	task automatic run_phase(input logic [NSTATES_W-1:0] n_cfg);
		int n;
		int k;
		int len;
		int r;
		int start;
		logic [SYM_W-1:0] alpha [4];
		dfa_req_t rq;
		settle();
		write_cfg(n_cfg);
		n = stride_of(n_cfg);
		k = $urandom_range(1, 4);
		for (int j = 0; j < 4; j++)
			alpha[2'(j)] = SYM_W'($urandom_range(0, 15));
		for (int s = 0; s < n; s++) begin
			for (int j = 0; j < k; j++) begin
				rq.kind = REQ_LOAD;
				rq.src = STATE_W'(s);
				rq.sym = alpha[2'(j)];
				rq.dst = STATE_W'($urandom_range(0, n - 1));
				rq.last = 1'($urandom_range(0, 1));
				send_item(rq, 1'b0, '0);
				req_pause();
			end
		end
		start = accept_cnt;
		while (accept_cnt - start < PHASE_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				send_random_load();
			end else if (r < 14) begin
				step_on(SYM_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			end else if (r < 16) begin
				settle();
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					step_on(alpha[2'($urandom_range(0, k - 1))], i == len - 1);
			end
		end
	endtask

	always @(posedge clk) begin : res_side
		verdict_t got;
		verdict_t want;
		int n;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got.state = res_bus.final_state;
			got.acc = res_bus.accepted;
			if (verdicts_due.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result final_state %0d accepted %0b",
					$time, got.state, got.acc);
			end else begin
				want = verdicts_due.pop_front();
				verdict_cnt++;
				if (got.state !== want.state) begin
					err_cnt++;
					$display("%0t: final_state expected %0d, got %0d",
						$time, want.state, got.state);
				end
				if (got.acc !== want.acc) begin
					err_cnt++;
					$display("%0t: accepted expected %0b, got %0b",
						$time, want.acc, got.acc);
				end
			end
		end
		if (stall_left > 0) begin
			res_bus.ready <= 1'b0;
			stall_left--;
		end else begin
			n = gap_len();
			res_bus.ready <= (n == 0);
			stall_left = (n > 0) ? n - 1 : 0;
		end
	end

	initial begin
		#8_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, verdicts_due.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [NSTATES_W-1:0] cfg_plan [8];
		dfa_req_t rq;
		verdict_t w;
		int phase;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_LOAD;
		req_bus.from_state = '0;
		req_bus.symbol = '0;
		req_bus.to_state = '0;
		req_bus.last = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		res_bus.ready = 1'b0;
		cfg_plan = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd1, 5'd15, 5'd3};
		// stride is 1 after reset: address = symbol + state
		script = '{
			'{REQ_LOAD, 4'd0,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_LOAD, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_LOAD, 4'd0,  4'd15, 4'd15, 1'b1, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd0,  4'd0,  4'd0,  1'b1, 1'b1, 4'd0,  1'b1},
			'{REQ_STEP, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd0,  4'd15, 4'd0,  1'b1, 1'b1, 4'd15, 1'b0},
			'{REQ_LOAD, 4'd15, 4'd0,  4'd3,  1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd0,  4'd15, 4'd0,  1'b1, 1'b0, 4'd0,  1'b0},
			'{REQ_LOAD, 4'd3,  4'd0,  4'd0,  1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd15, 4'd0,  4'd15, 1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd0,  4'd15, 4'd0,  1'b0, 1'b0, 4'd0,  1'b0},
			'{REQ_STEP, 4'd0,  4'd0,  4'd0,  1'b1, 1'b0, 4'd0,  1'b0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i]) begin
			rq.kind = script[i].kind;
			rq.src = script[i].src;
			rq.sym = script[i].sym;
			rq.dst = script[i].dst;
			rq.last = script[i].last;
			w.state = script[i].want_state;
			w.acc = script[i].want_acc;
			send_item(rq, script[i].typed, w);
			req_pause();
		end
		phase = 0;
		while (accept_cnt < ITEM_TARGET) begin
			quiet = (phase % 3 == 1);
			run_phase(phase < 8 ? cfg_plan[3'(phase)] : NSTATES_W'($urandom_range(0, 31)));
			phase++;
		end
		quiet = 1'b0;
		settle();
		$display("covered %0d transfers: %0d table loads, %0d symbol steps, %0d strings checked",
			accept_cnt, load_cnt, step_cnt, verdict_cnt);
		$display("over %0d stride settings including 0, 1, 16 and above 16", cfg_cnt);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
